[design/two_link_leg_inverse_kinematics_core_defines.svh]
// Assertion macros for the two-link leg IK core checker.
// No dependencies; included by the checker file only.
`ifndef TWO_LINK_LEG_INVERSE_KINEMATICS_CORE_DEFINES_SVH
`define TWO_LINK_LEG_INVERSE_KINEMATICS_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define TLIK_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tlik check failed");

// next-cycle implication, off during reset
`define TLIK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tlik check failed");

// next-cycle implication, also checked in reset
`define TLIK_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tlik check failed");

`endif

[design/tlik_pkg.sv]
// Shared types, constants and the arctangent table for the two-link IK core.
// No dependencies.
`timescale 1ns / 1ps
package tlik_pkg;

  localparam int SQ_CELLS = 23;
  localparam logic [32:0] REACH_SQ = 33'd400000000;
  localparam logic [30:0] TWO_PI_Q28 = 31'd1686629713;
  localparam logic signed [35:0] HALF_TURN = 36'sd2147483648;
  localparam logic signed [35:0] QUARTER_TURN = 36'sd1073741824;

  typedef logic signed [33:0] ang_t;

  typedef struct packed {
    logic        unreach;
    logic        x_neg;
    logic        x_zero;
    logic [16:0] ax;
    logic [15:0] y;
  } pass_t;

  typedef struct packed {
    logic [45:0] rem_p;
    logic [45:0] rem_q;
    logic [45:0] root_p;
    logic [45:0] root_q;
  } sq_t;

  typedef struct packed {
    logic [39:0] a;
    logic [39:0] b;
    logic [33:0] z;
  } vec_t;

  typedef struct packed {
    logic unreach;
    logic x_neg;
    logic x_zero;
    vec_t hv;
    vec_t tv;
  } cd_t;

  // atan(2^-i), 2^32 units per turn
  function automatic ang_t atan_entry(input int i);
    case (i)
      0:       return 34'sh020000000;
      1:       return 34'sh012E4051D;
      2:       return 34'sh009FB385B;
      3:       return 34'sh0051111D4;
      4:       return 34'sh0028B0D43;
      5:       return 34'sh00145D7E1;
      6:       return 34'sh000A2F61E;
      7:       return 34'sh000517C55;
      8:       return 34'sh00028BE53;
      9:       return 34'sh000145F2F;
      10:      return 34'sh0000A2F98;
      11:      return 34'sh0000517CC;
      12:      return 34'sh000028BE6;
      13:      return 34'sh0000145F3;
      14:      return 34'sh00000A2F9;
      15:      return 34'sh00000517C;
      16:      return 34'sh0000028BE;
      17:      return 34'sh00000145F;
      18:      return 34'sh000000A2F;
      19:      return 34'sh000000517;
      20:      return 34'sh00000028B;
      21:      return 34'sh000000145;
      22:      return 34'sh0000000A2;
      23:      return 34'sh000000051;
      default: return '0;
    endcase
  endfunction

endpackage

[design/tlik_ifs.sv]
// Valid/ready channel interfaces for the two-link IK core.
// No dependencies.
`timescale 1ns / 1ps
interface tlik_in_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] x_pos;
  logic [15:0]       y_pos;
  modport source (output valid, x_pos, y_pos, input ready);
  modport sink (input valid, x_pos, y_pos, output ready);
endinterface

interface tlik_out_if;
  logic              valid;
  logic              ready;
  logic [14:0]       upper_angle;
  logic signed [13:0] lower_angle;
  logic              unreachable;
  modport source (output valid, upper_angle, lower_angle, unreachable, input ready);
  modport sink (input valid, upper_angle, lower_angle, unreachable, output ready);
endinterface

[design/two_link_leg_inverse_kinematics_core.sv]
// Two-link leg inverse kinematics: a fully pipelined chain that takes one foot
// target per cycle unless the output stalls, and returns upper/lower joint angles
// in radians (Q.ANGLE_FRAC_BITS). The chain has one cell for the squared distance,
// 23 digit cells for the two square roots, one CORDIC cell per stage, and three
// cells for scaling and saturation. Every cell holds one target and has its own
// valid bit, so a stalled output only backs up as far as the chain is full.
// Depends on tlik_pkg, tlik_ifs and the cell modules.
`timescale 1ns / 1ps
module two_link_leg_inverse_kinematics_core #(
  parameter int CORDIC_STAGES = 16,
  parameter int ANGLE_FRAC_BITS = 12
) (
  input  logic       clk,
  input  logic       rst_n,
  tlik_in_if.sink    in_chan,
  tlik_out_if.source out_chan
);
  import tlik_pkg::*;

  logic  sq_v   [0:SQ_CELLS];
  logic  sq_rdy [0:SQ_CELLS];
  pass_t sq_pass[0:SQ_CELLS];
  sq_t   sq_d   [0:SQ_CELLS];

  logic cd_v   [0:CORDIC_STAGES];
  logic cd_rdy [0:CORDIC_STAGES];
  cd_t  cd_d   [0:CORDIC_STAGES];

  tlik_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_chan.valid), .in_ready(in_chan.ready),
    .x_pos(in_chan.x_pos), .y_pos(in_chan.y_pos),
    .out_valid(sq_v[0]), .out_ready(sq_rdy[0]),
    .out_pass(sq_pass[0]), .out_sq(sq_d[0])
  );

  for (genvar k = 0; k < SQ_CELLS; k++) begin : g_sqrt
    tlik_sqrt_cell #(.K(k)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .in_valid(sq_v[k]), .in_ready(sq_rdy[k]),
      .in_pass(sq_pass[k]), .in_sq(sq_d[k]),
      .out_valid(sq_v[k+1]), .out_ready(sq_rdy[k+1]),
      .out_pass(sq_pass[k+1]), .out_sq(sq_d[k+1])
    );
  end

  assign cd_v[0] = sq_v[SQ_CELLS];
  assign sq_rdy[SQ_CELLS] = cd_rdy[0];

  always_comb begin
    cd_d[0].unreach = sq_pass[SQ_CELLS].unreach;
    cd_d[0].x_neg = sq_pass[SQ_CELLS].x_neg;
    cd_d[0].x_zero = sq_pass[SQ_CELLS].x_zero;
    cd_d[0].hv.a = {9'b0, sq_d[SQ_CELLS].root_q[22:0], 8'b0};
    cd_d[0].hv.b = {9'b0, sq_d[SQ_CELLS].root_p[22:0], 8'b0};
    cd_d[0].hv.z = '0;
    cd_d[0].tv.a = {7'b0, sq_pass[SQ_CELLS].ax, 16'b0};
    cd_d[0].tv.b = {8'b0, sq_pass[SQ_CELLS].y, 16'b0};
    cd_d[0].tv.z = '0;
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    tlik_cordic_cell #(.I(i)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .in_valid(cd_v[i]), .in_ready(cd_rdy[i]), .in_cd(cd_d[i]),
      .out_valid(cd_v[i+1]), .out_ready(cd_rdy[i+1]), .out_cd(cd_d[i+1])
    );
  end

  tlik_post #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_post (
    .clk(clk), .rst_n(rst_n),
    .in_valid(cd_v[CORDIC_STAGES]), .in_ready(cd_rdy[CORDIC_STAGES]),
    .in_cd(cd_d[CORDIC_STAGES]),
    .out_valid(out_chan.valid), .out_ready(out_chan.ready),
    .upper_angle(out_chan.upper_angle), .lower_angle(out_chan.lower_angle),
    .unreachable(out_chan.unreachable)
  );
endmodule

[design/tlik_front.sv]
// Front cell: squared distance, reach test and square-root operands.
// Depends on tlik_pkg.
`timescale 1ns / 1ps
module tlik_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] x_pos,
  input  logic [15:0]        y_pos,
  output logic               out_valid,
  input  logic               out_ready,
  output tlik_pkg::pass_t    out_pass,
  output tlik_pkg::sq_t      out_sq
);
  import tlik_pkg::*;

  logic               v_r;
  pass_t              pass_r, pass_nxt;
  sq_t                sq_r, sq_nxt;
  logic signed [31:0] xx;
  logic [31:0]        yy;
  logic [32:0]        s;
  logic [28:0]        d;

  always_comb begin
    xx = x_pos * x_pos;
    yy = y_pos * y_pos;
    s = {1'b0, xx} + {1'b0, yy};
    d = REACH_SQ[28:0] - s[28:0];
    pass_nxt.unreach = s > REACH_SQ;
    pass_nxt.x_neg = x_pos[15];
    pass_nxt.x_zero = x_pos == 16'sd0;
    pass_nxt.ax = x_pos[15] ? 17'(-{x_pos[15], x_pos}) : {1'b0, x_pos};
    pass_nxt.y = y_pos;
    sq_nxt.rem_p = {1'b0, s[28:0], 16'b0};
    sq_nxt.rem_q = {1'b0, d, 16'b0};
    sq_nxt.root_p = '0;
    sq_nxt.root_q = '0;
  end

  assign in_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      pass_r <= pass_nxt;
      sq_r <= sq_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_pass = pass_r;
  assign out_sq = sq_r;
endmodule

[design/tlik_sqrt_cell.sv]
// One digit cell of the pipelined integer square roots (both roots at once).
// Depends on tlik_pkg.
`timescale 1ns / 1ps
module tlik_sqrt_cell #(
  parameter int K = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  tlik_pkg::pass_t in_pass,
  input  tlik_pkg::sq_t   in_sq,
  output logic            out_valid,
  input  logic            out_ready,
  output tlik_pkg::pass_t out_pass,
  output tlik_pkg::sq_t   out_sq
);
  import tlik_pkg::*;

  localparam logic [45:0] BIT = 46'd1 << (44 - 2 * K);

  logic  v_r;
  pass_t pass_r;
  sq_t   sq_r, sq_nxt;
  logic [45:0] tp, tq;

  always_comb begin
    tp = in_sq.root_p + BIT;
    tq = in_sq.root_q + BIT;
    sq_nxt = in_sq;
    if (in_sq.rem_p >= tp) begin
      sq_nxt.rem_p = in_sq.rem_p - tp;
      sq_nxt.root_p = (in_sq.root_p >> 1) + BIT;
    end else begin
      sq_nxt.root_p = in_sq.root_p >> 1;
    end
    if (in_sq.rem_q >= tq) begin
      sq_nxt.rem_q = in_sq.rem_q - tq;
      sq_nxt.root_q = (in_sq.root_q >> 1) + BIT;
    end else begin
      sq_nxt.root_q = in_sq.root_q >> 1;
    end
  end

  assign in_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      pass_r <= in_pass;
      sq_r <= sq_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_pass = pass_r;
  assign out_sq = sq_r;
endmodule

[design/tlik_cordic_cell.sv]
// One vectoring CORDIC cell; rotates the knee and the target vectors together.
// Depends on tlik_pkg.
`timescale 1ns / 1ps
module tlik_cordic_cell #(
  parameter int I = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  tlik_pkg::cd_t in_cd,
  output logic          out_valid,
  input  logic          out_ready,
  output tlik_pkg::cd_t out_cd
);
  import tlik_pkg::*;

  localparam ang_t TAB = atan_entry(I);

  logic v_r;
  cd_t  cd_r, cd_nxt;

  function automatic vec_t rotate(input vec_t v);
    logic signed [39:0] a, b, da, db;
    logic signed [33:0] z;
    vec_t               r;
    a = $signed(v.a);
    b = $signed(v.b);
    z = $signed(v.z);
    da = b >>> I;
    db = a >>> I;
    if (!b[39]) begin
      a = a + da;
      b = b - db;
      z = z + TAB;
    end else begin
      a = a - da;
      b = b + db;
      z = z - TAB;
    end
    r.a = a;
    r.b = b;
    r.z = z;
    return r;
  endfunction

  always_comb begin
    cd_nxt = in_cd;
    cd_nxt.hv = rotate(in_cd.hv);
    cd_nxt.tv = rotate(in_cd.tv);
  end

  assign in_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cd_r <= cd_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_cd = cd_r;
endmodule

[design/tlik_post.sv]
// Back end: joint angles, radian scaling with rounding, saturation, output register.
// Depends on tlik_pkg.
`timescale 1ns / 1ps
module tlik_post #(
  parameter int ANGLE_FRAC_BITS = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tlik_pkg::cd_t      in_cd,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [14:0]        upper_angle,
  output logic signed [13:0] lower_angle,
  output logic               unreachable
);
  import tlik_pkg::*;

  localparam int SH = 60 - ANGLE_FRAC_BITS;

  logic a_v_r, b_v_r, c_v_r;
  logic rdy_a, rdy_b, rdy_c;

  logic        a_unr_r, a_neg_u_r, a_neg_l_r;
  logic [33:0] a_mag_u_r, a_mag_l_r;
  logic        b_unr_r, b_neg_u_r, b_neg_l_r;
  logic [64:0] b_prod_u_r, b_prod_l_r;
  logic [14:0]        up_r, up_nxt;
  logic signed [13:0] lo_r, lo_nxt;
  logic               unr_r;

  logic signed [35:0] hz, ts, alpha, up_ang, lo_ang;
  logic [65:0]        rnd_u, rnd_l, r_u, r_l;

  function automatic logic [33:0] clamp_mag(input logic signed [35:0] v);
    logic [35:0] m;
    m = v[35] ? 36'(-v) : 36'(v);
    return (m > 36'h200000000) ? 34'h200000000 : m[33:0];
  endfunction

  assign rdy_c = !c_v_r || out_ready;
  assign rdy_b = !b_v_r || rdy_c;
  assign rdy_a = !a_v_r || rdy_b;
  assign in_ready = rdy_a;

  always_comb begin
    hz = 36'($signed(in_cd.hv.z));
    ts = in_cd.x_neg ? -36'($signed(in_cd.tv.z)) : 36'($signed(in_cd.tv.z));
    alpha = in_cd.x_zero ? hz : ts - QUARTER_TURN + hz;
    up_ang = HALF_TURN - alpha;
    lo_ang = (hz <<< 1) - QUARTER_TURN;
  end

  always_comb begin
    rnd_u = {1'b0, b_prod_u_r} + (66'd1 << (SH - 1));
    rnd_l = {1'b0, b_prod_l_r} + (66'd1 << (SH - 1));
    r_u = rnd_u >> SH;
    r_l = rnd_l >> SH;
    if (b_unr_r || b_neg_u_r) begin
      up_nxt = '0;
    end else if (r_u > 66'd32767) begin
      up_nxt = 15'd32767;
    end else begin
      up_nxt = r_u[14:0];
    end
    if (b_unr_r) begin
      lo_nxt = '0;
    end else if (b_neg_l_r) begin
      lo_nxt = (r_l > 66'd8192) ? -14'sd8192 : 14'(-$signed({1'b0, r_l[13:0]}));
    end else begin
      lo_nxt = (r_l > 66'd8191) ? 14'sd8191 : $signed(r_l[13:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      if (rdy_a) a_v_r <= in_valid;
      if (rdy_b) b_v_r <= a_v_r;
      if (rdy_c) c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      a_unr_r <= in_cd.unreach;
      a_neg_u_r <= up_ang[35];
      a_neg_l_r <= lo_ang[35];
      a_mag_u_r <= clamp_mag(up_ang);
      a_mag_l_r <= clamp_mag(lo_ang);
    end
    if (rdy_b && a_v_r) begin
      b_unr_r <= a_unr_r;
      b_neg_u_r <= a_neg_u_r;
      b_neg_l_r <= a_neg_l_r;
      b_prod_u_r <= 65'(a_mag_u_r) * 65'(TWO_PI_Q28);
      b_prod_l_r <= 65'(a_mag_l_r) * 65'(TWO_PI_Q28);
    end
    if (rdy_c && b_v_r) begin
      up_r <= up_nxt;
      lo_r <= lo_nxt;
      unr_r <= b_unr_r;
    end
  end

  assign out_valid = c_v_r;
  assign upper_angle = up_r;
  assign lower_angle = lo_r;
  assign unreachable = unr_r;
endmodule

[design/tlik_checker.sv]
// Port-level checker for the two-link IK core, bound to the top level.
// Depends on the assertion macro header.
`timescale 1ns / 1ps
`include "two_link_leg_inverse_kinematics_core_defines.svh"
module tlik_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [14:0]        out_upper_angle,
  input logic signed [13:0] out_lower_angle,
  input logic               out_unreachable
);
  `TLIK_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `TLIK_ASSERT_NOW(a_unr_zero, out_valid && out_unreachable, out_upper_angle == 15'd0 && out_lower_angle == 14'sd0)
  `TLIK_ASSERT_NOW(a_flow, out_ready, in_ready)
  `TLIK_ASSERT_RST(a_reset_empty, !rst_n, !out_valid)
  `TLIK_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_upper_angle) && $stable(out_lower_angle) && $stable(out_unreachable))
endmodule

bind two_link_leg_inverse_kinematics_core tlik_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_ready(in_chan.ready),
  .out_valid(out_chan.valid), .out_ready(out_chan.ready),
  .out_upper_angle(out_chan.upper_angle), .out_lower_angle(out_chan.lower_angle),
  .out_unreachable(out_chan.unreachable)
);

[dv/two_link_leg_inverse_kinematics_core_tb.sv]
// Testbench for the two-link leg IK core: random and directed foot targets,
// handshake idling on both sides, results checked against an in-bench predictor.
// Depends on tlik_pkg, tlik_ifs and the core RTL.
`timescale 1ns / 1ps

class leg_angle_scoreboard;
  localparam int STAGES = 16;
  localparam int FRAC = 12;
  typedef struct {
    logic [14:0]        upper;
    logic signed [13:0] lower;
    logic               unreach;
  } angles_t;

  angles_t pending_angles[$];
  int mismatches;

  function longint unsigned root_floor(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function longint vector_angle(longint a, longint b);
    longint z;
    longint da;
    longint db;
    z = 0;
    for (int i = 0; i < STAGES; i++) begin
      da = b >>> i;
      db = a >>> i;
      if (b >= 0) begin
        a += da;
        b -= db;
        z += longint'(tlik_pkg::atan_entry(i));
      end else begin
        a -= da;
        b += db;
        z -= longint'(tlik_pkg::atan_entry(i));
      end
    end
    return z;
  endfunction

  function longint to_radians(longint ang);
    bit neg;
    longint unsigned m;
    longint unsigned r;
    int sh;
    neg = ang < 0;
    m = neg ? longint'(-ang) : ang;
    sh = 60 - FRAC;
    if (m > (64'd1 << 33)) m = 64'd1 << 33;
    r = (m * 64'd1686629713 + (64'd1 << (sh - 1))) >> sh;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function void note_target(logic signed [15:0] xp, logic [15:0] yp);
    angles_t e;
    longint x;
    longint y;
    longint unsigned s;
    longint unsigned p;
    longint unsigned q;
    longint half;
    longint alpha;
    longint t;
    longint up;
    longint lo;
    x = xp;
    y = yp;
    s = x * x + y * y;
    if (s > 64'd400000000) begin
      e.upper = 0;
      e.lower = 0;
      e.unreach = 1;
    end else begin
      p = root_floor(s << 16);
      q = root_floor((64'd400000000 - s) << 16);
      half = vector_angle(longint'(q << 8), longint'(p << 8));
      if (x == 0) begin
        alpha = half;
      end else begin
        t = vector_angle((x < 0 ? -x : x) * 65536, y * 65536);
        if (x < 0) t = -t;
        alpha = t - 64'sd1073741824 + half;
      end
      up = to_radians(64'sd2147483648 - alpha);
      lo = to_radians(2 * half - 64'sd1073741824);
      if (up < 0) up = 0;
      if (up > 32767) up = 32767;
      if (lo < -8192) lo = -8192;
      if (lo > 8191) lo = 8191;
      e.upper = up[14:0];
      e.lower = lo[13:0];
      e.unreach = 0;
    end
    pending_angles.push_back(e);
  endfunction

  function void check_angles(logic [14:0] up, logic signed [13:0] lo, logic un);
    angles_t e;
    if (pending_angles.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result transfer: %0d %0d %0b", up, lo, un);
      return;
    end
    e = pending_angles.pop_front();
    if (e.upper !== up || e.lower !== lo || e.unreach !== un) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp %0d %0d %0b, got %0d %0d %0b",
                 e.upper, e.lower, e.unreach, up, lo, un);
    end
  endfunction
endclass

module two_link_leg_inverse_kinematics_core_tb;
  logic clk = 0;
  logic rst_n = 0;
  tlik_in_if in_chan();
  tlik_out_if out_chan();
  leg_angle_scoreboard board;
  bit calm;
  int idle_cycles;

  two_link_leg_inverse_kinematics_core dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  initial begin
    in_chan.valid = 0;
    in_chan.x_pos = 0;
    in_chan.y_pos = 0;
    out_chan.ready = 0;
  end

  always @(posedge clk) begin
    if (rst_n) out_chan.ready <= calm || ($urandom_range(99) >= 34);
    if (rst_n && out_chan.valid && out_chan.ready)
      board.check_angles(out_chan.upper_angle, out_chan.lower_angle, out_chan.unreachable);
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_target(logic signed [15:0] xp, logic [15:0] yp);
    while (!calm && $urandom_range(99) < 34) begin
      in_chan.valid <= 0;
      @(posedge clk);
    end
    in_chan.valid <= 1;
    in_chan.x_pos <= xp;
    in_chan.y_pos <= yp;
    do @(posedge clk); while (!in_chan.ready);
    board.note_target(xp, yp);
  endtask

  task automatic flush_pending();
    in_chan.valid <= 0;
    do @(posedge clk); while (board.pending_angles.size() != 0);
  endtask

  task automatic send_reachable();
    int r;
    int xv;
    int yv;
    r = $urandom_range(20000);
    xv = $urandom_range(2 * r) - r;
    yv = $urandom_range(r);
    if ($urandom_range(9) == 0) xv = 0;
    send_target(16'(xv), 16'(yv));
  endtask

  initial begin
    board = new();
    idle_cycles = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_target(0, 0);
    send_target(0, 20000);
    send_target(20000, 0);
    send_target(-20000, 0);
    send_target(0, 20001);
    send_target(-32768, 0);
    send_target(32767, 65535);
    send_target(0, 65535);
    send_target(-1, 1);
    send_target(1, 1);
    send_target(14142, 14142);
    send_target(-14142, 14142);
    send_target(-32768, 65535);
    send_target(10000, 10000);
    send_target(-5000, 15000);
    send_target(16'h5555, 16'haaaa);
    send_target(16'h2aaa, 16'h5555);
    flush_pending();
    for (int i = 0; i < 1650; i++) begin
      calm = (i >= 600 && i < 800);
      if (i == 1000)
        flush_pending();
      if ($urandom_range(99) < 80) send_reachable();
      else send_target(16'($urandom), 16'($urandom));
    end
    calm = 0;
    flush_pending();
    repeat (60) @(posedge clk);
    if (board.mismatches == 0 && board.pending_angles.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+design
design/tlik_pkg.sv
design/tlik_ifs.sv
design/tlik_front.sv
design/tlik_sqrt_cell.sv
design/tlik_cordic_cell.sv
design/tlik_post.sv
design/two_link_leg_inverse_kinematics_core.sv
design/tlik_checker.sv
dv/two_link_leg_inverse_kinematics_core_tb.sv
